// File: hdl/ansi_escape_command_engine_macros.svh
// ---------------------------------------------------------------------------
// ansi_escape_command_engine assertion macros
// Clocked assertion shorthands shared by the engine's modules.
// ---------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_COMMAND_ENGINE_MACROS_SVH
`define ANSI_ESCAPE_COMMAND_ENGINE_MACROS_SVH

// property holds at every edge outside reset
`define AECE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define AECE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/aece_pkg.sv
// ---------------------------------------------------------------------------
// aece_pkg
// Types, codes and constant tables of the escape command engine.
// ---------------------------------------------------------------------------
`default_nettype none

package aece_pkg;

	localparam int DEF_SCREEN_ROWS = 24;
	localparam int DEF_SCREEN_COLS = 80;
	localparam int DEF_MAX_PARAMS  = 8;
	localparam int DEF_PARAM_CHARS = 5;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_FORE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_BACK = 1'b1;

	localparam logic [7:0] RST_DEF_FORE = 8'd7;
	localparam logic [7:0] RST_DEF_BACK = 8'd0;

	localparam logic [2:0] KIND_DRAW        = 3'd0;
	localparam logic [2:0] KIND_SCROLL_UP   = 3'd1;
	localparam logic [2:0] KIND_SCROLL_DOWN = 3'd2;
	localparam logic [2:0] KIND_CLEAR_ROWS  = 3'd3;
	localparam logic [2:0] KIND_CLEAR_COLS  = 3'd4;
	localparam logic [2:0] KIND_TRANSMIT    = 3'd5;
	localparam logic [2:0] KIND_RESET       = 3'd6;

	localparam logic [1:0] TX_NONE = 2'd0;
	localparam logic [1:0] TX_DA   = 2'd1;
	localparam logic [1:0] TX_DSR  = 2'd2;

	localparam logic [7:0] CH_ESC = 8'd27;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  pos_row;
		logic [7:0]  pos_col;
		logic [7:0]  span_end;
		logic [15:0] value;
		logic [1:0]  font_kind;
		logic        italic_on;
		logic        underline_on;
		logic        strike_on;
		logic [7:0]  fore_color;
		logic [7:0]  back_color;
	} result_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic sgr_step;
		logic emit_slot0;
		logic emit_slot1;
		logic emit_tx;
		logic last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic slot0_v;
		logic slot1_v;
		logic tx_pending;
		logic tx_last;
		logic sgr_pending;
		logic sgr_done;
		logic out_free;
	} dp_status_t;

	function automatic result_t mk_cmd(input logic [2:0] kind, input logic [7:0] row,
			input logic [7:0] col, input logic [7:0] span, input logic [15:0] val,
			input logic [7:0] back);
		result_t r;
		r = '0;
		r.kind = kind;
		r.pos_row = row;
		r.pos_col = col;
		r.span_end = span;
		r.value = val;
		r.back_color = back;
		return r;
	endfunction

	function automatic logic [2:0] tx_len_m1(input logic [1:0] tk);
		logic [2:0] n;
		n = (tk == TX_DA) ? 3'd6 : 3'd3;
		return n;
	endfunction

	function automatic logic [7:0] tx_byte(input logic [1:0] tk, input logic [2:0] idx);
		logic [7:0] b;
		b = CH_ESC;
		if (tk == TX_DA) begin
			case (idx)
				3'd0: b = CH_ESC;
				3'd1: b = "[";
				3'd2: b = "?";
				3'd3: b = "1";
				3'd4: b = ";";
				3'd5: b = "0";
				3'd6: b = "c";
				default: b = CH_ESC;
			endcase
		end else begin
			case (idx)
				3'd0: b = CH_ESC;
				3'd1: b = "[";
				3'd2: b = "0";
				3'd3: b = "n";
				default: b = CH_ESC;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// File: hdl/aece_ctrl.sv
// ---------------------------------------------------------------------------
// aece_ctrl
// Sequencer: capture, execute, SGR walk and command emission.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ansi_escape_command_engine_macros.svh"

module aece_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  aece_pkg::dp_status_t  status,
	output aece_pkg::ctrl_cmd_t   cmd
);
	import aece_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_ROUTE = 3'd2;
	localparam logic [2:0] S_SGR   = 3'd3;
	localparam logic [2:0] S_EMIT0 = 3'd4;
	localparam logic [2:0] S_EMIT1 = 3'd5;
	localparam logic [2:0] S_TX    = 3'd6;

	logic [2:0] state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_n = S_ROUTE;
			end
			S_ROUTE: begin
				if (status.sgr_pending)
					state_n = S_SGR;
				else if (status.slot0_v)
					state_n = S_EMIT0;
				else if (status.slot1_v)
					state_n = S_EMIT1;
				else if (status.tx_pending)
					state_n = S_TX;
				else
					state_n = S_IDLE;
			end
			S_SGR: begin
				if (status.sgr_done)
					state_n = S_IDLE;
				else
					cmd.sgr_step = 1'b1;
			end
			S_EMIT0: begin
				if (status.out_free) begin
					cmd.emit_slot0 = 1'b1;
					cmd.last = !status.slot1_v && !status.tx_pending;
					if (status.slot1_v)
						state_n = S_EMIT1;
					else if (status.tx_pending)
						state_n = S_TX;
					else
						state_n = S_IDLE;
				end
			end
			S_EMIT1: begin
				if (status.out_free) begin
					cmd.emit_slot1 = 1'b1;
					cmd.last = !status.tx_pending;
					state_n = status.tx_pending ? S_TX : S_IDLE;
				end
			end
			S_TX: begin
				if (status.out_free) begin
					cmd.emit_tx = 1'b1;
					cmd.last = status.tx_last;
					if (status.tx_last)
						state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	`AECE_ASSERT(a_one_action, $onehot0({cmd.capture, cmd.exec, cmd.sgr_step, cmd.emit_slot0, cmd.emit_slot1, cmd.emit_tx}), "more than one datapath action")
	`AECE_ASSERT(a_emit_free, !(cmd.emit_slot0 || cmd.emit_slot1 || cmd.emit_tx) || status.out_free, "emit into a full output register")
	`AECE_ASSERT_NEXT(a_exec_after_capture, cmd.capture, cmd.exec, "captured beat not executed")

endmodule

`default_nettype wire

// File: hdl/aece_dp.sv
// ---------------------------------------------------------------------------
// aece_dp
// Parser state, cursor, attributes, command slots and output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ansi_escape_command_engine_macros.svh"

module aece_dp #(
	parameter int SCREEN_ROWS = aece_pkg::DEF_SCREEN_ROWS,
	parameter int SCREEN_COLS = aece_pkg::DEF_SCREEN_COLS,
	parameter int MAX_PARAMS  = aece_pkg::DEF_MAX_PARAMS,
	parameter int PARAM_CHARS = aece_pkg::DEF_PARAM_CHARS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  [7:0]                      rx_byte,
	input  aece_pkg::ctrl_cmd_t             cmd,
	output aece_pkg::dp_status_t            status,
	input  wire                             cfg_we,
	input  wire  [aece_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [7:0]                      cfg_data,
	output logic                            out_valid,
	input  wire                             out_ready,
	output aece_pkg::result_t               out_res,
	output logic                            out_last
);
	import aece_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARAMS);
	localparam int CNT_W = $clog2(MAX_PARAMS + 1);
	localparam int DIG_W = $clog2(PARAM_CHARS);
	localparam int K_W   = $clog2(MAX_PARAMS + 6);

	localparam logic [7:0] ROWS8    = 8'(SCREEN_ROWS);
	localparam logic [7:0] COLS8    = 8'(SCREEN_COLS);
	localparam logic [7:0] ROW_LAST = 8'(SCREEN_ROWS - 1);
	localparam logic [7:0] COL_LAST = 8'(SCREEN_COLS - 1);

	localparam logic [1:0] MODE_GROUND = 2'd0;
	localparam logic [1:0] MODE_ESC    = 2'd1;
	localparam logic [1:0] MODE_CSI    = 2'd2;
	localparam logic [1:0] MODE_HASH   = 2'd3;

	localparam logic [1:0] SG_NORMAL = 2'd0;
	localparam logic [1:0] SG_SUB    = 2'd1;
	localparam logic [1:0] SG_VAL    = 2'd2;

	// style bits
	localparam int ST_ITALIC  = 0;
	localparam int ST_UNDER   = 1;
	localparam int ST_NEG     = 2;
	localparam int ST_CONCEAL = 3;
	localparam int ST_CROSS   = 4;

	logic [7:0]        def_fore_q, def_back_q;
	logic [7:0]        byte_q;
	logic [1:0]        mode_q;
	logic [15:0]       vals_q [MAX_PARAMS];
	logic [CNT_W-1:0]  count_q;
	logic [DIG_W-1:0]  digits_q;
	logic [7:0]        row_q, col_q;
	logic              wrap_q;
	logic [1:0]        font_q;
	logic [4:0]        style_q;
	logic [7:0]        fore_q, back_q;
	result_t           slot0_q, slot1_q;
	logic              slot0_v_q, slot1_v_q;
	logic [1:0]        tx_kind_q;
	logic [2:0]        tx_idx_q;
	logic              sgr_pend_q;
	logic [K_W-1:0]    sgr_k_q;
	logic [1:0]        sgr_phase_q;
	logic              sgr_back_q;
	logic              out_valid_q;
	result_t           out_q;
	logic              out_last_q;

	// execute-step next values
	logic [1:0]        mode_n;
	logic [CNT_W-1:0]  count_n;
	logic [DIG_W-1:0]  digits_n;
	logic [7:0]        row_n, col_n;
	logic              wrap_n;
	logic              clr_prm, do_rst, wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [15:0]       wr_old, wr_data;
	result_t           s0, s1;
	logic              s0v, s1v;
	logic [1:0]        tx_n;
	logic              sgr_n;
	logic [15:0]       p0, p1, pn;
	logic [16:0]       row_plus, col_plus;
	logic [7:0]        dr_row, dr_col;
	logic [3:0]        digit;
	logic              neg;

	// SGR step
	logic [15:0]       prm_k;
	logic              sgr_done;
	logic [K_W-1:0]    k_n;
	logic [1:0]        phase_n;
	logic              tgt_n;
	logic [1:0]        sfont_n;
	logic [4:0]        sstyle_n;
	logic [7:0]        sfore_n, sback_n;

	assign p0 = vals_q[0];
	assign p1 = vals_q[1];
	assign pn = (p0 == 16'd0) ? 16'd1 : p0;
	assign row_plus = {9'd0, row_q} + {1'b0, pn};
	assign col_plus = {9'd0, col_q} + {1'b0, pn};
	assign digit = byte_q[3:0];
	assign neg = style_q[ST_NEG];
	assign wr_old = vals_q[wr_idx];
	assign wr_data = (wr_old << 3) + (wr_old << 1) + {12'd0, digit};

	always_comb begin
		mode_n = mode_q;
		count_n = count_q;
		digits_n = digits_q;
		row_n = row_q;
		col_n = col_q;
		wrap_n = wrap_q;
		clr_prm = 1'b0;
		do_rst = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		s0 = '0;
		s1 = '0;
		s0v = 1'b0;
		s1v = 1'b0;
		tx_n = TX_NONE;
		sgr_n = 1'b0;
		dr_row = row_q;
		dr_col = wrap_q ? 8'd0 : col_q;
		if (byte_q == CH_CR) begin
			col_n = 8'd0;
			wrap_n = 1'b0;
		end else if (byte_q == CH_LF) begin
			if (row_q == ROW_LAST) begin
				s0 = mk_cmd(KIND_SCROLL_UP, 8'd0, 8'd0, ROWS8, 16'd1, def_back_q);
				s0v = 1'b1;
			end else
				row_n = row_q + 8'd1;
		end else if (byte_q == CH_ESC) begin
			mode_n = MODE_ESC;
		end else if (mode_q == MODE_GROUND) begin
			// deferred wrap lands first, then the cell is drawn
			if (wrap_q) begin
				if (row_q == ROW_LAST) begin
					s0 = mk_cmd(KIND_SCROLL_UP, 8'd0, 8'd0, ROWS8, 16'd1, def_back_q);
					s0v = 1'b1;
				end else
					dr_row = row_q + 8'd1;
			end
			s1 = mk_cmd(KIND_DRAW, dr_row, dr_col, 8'd0, {8'd0, byte_q}, 8'd0);
			s1.font_kind = font_q;
			s1.italic_on = style_q[ST_ITALIC];
			s1.underline_on = style_q[ST_UNDER];
			s1.strike_on = style_q[ST_CROSS];
			s1.fore_color = neg ? back_q : fore_q;
			s1.back_color = neg ? fore_q : back_q;
			s1v = !style_q[ST_CONCEAL];
			row_n = dr_row;
			wrap_n = (dr_col == COL_LAST);
			col_n = (dr_col == COL_LAST) ? dr_col : dr_col + 8'd1;
		end else if (mode_q == MODE_ESC) begin
			if (byte_q == "[") begin
				mode_n = MODE_CSI;
				clr_prm = 1'b1;
				count_n = '0;
				digits_n = '0;
			end else if (byte_q == "#") begin
				mode_n = MODE_HASH;
			end else if (byte_q == "c") begin
				s0 = mk_cmd(KIND_RESET, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0);
				s0v = 1'b1;
				do_rst = 1'b1;
			end else
				mode_n = MODE_GROUND;
		end else if (mode_q == MODE_CSI) begin
			if (byte_q >= "0" && byte_q <= "9") begin
				if (digits_q == '0) begin
					if (count_q < CNT_W'(MAX_PARAMS)) begin
						count_n = count_q + CNT_W'(1);
						wr_idx = count_q[IDX_W-1:0];
						wr_en = 1'b1;
						digits_n = DIG_W'(1);
					end
				end else if (digits_q < DIG_W'(PARAM_CHARS - 1)) begin
					wr_idx = IDX_W'(count_q - CNT_W'(1));
					wr_en = 1'b1;
					digits_n = digits_q + DIG_W'(1);
				end
			end else if (byte_q == ";") begin
				if (digits_q == '0) begin
					if (count_q < CNT_W'(MAX_PARAMS))
						count_n = count_q + CNT_W'(1);
				end else
					digits_n = '0;
			end else begin
				mode_n = MODE_GROUND;
				case (byte_q)
					"c": tx_n = TX_DA;
					"n": if (p0 == 16'd5) tx_n = TX_DSR;
					"f", "H": begin
						wrap_n = 1'b0;
						if (p0 == 16'd0)
							row_n = 8'd0;
						else if (p0 >= 16'(SCREEN_ROWS))
							row_n = ROW_LAST;
						else
							row_n = p0[7:0] - 8'd1;
						if (p1 == 16'd0)
							col_n = 8'd0;
						else if (p1 >= 16'(SCREEN_COLS))
							col_n = COL_LAST;
						else
							col_n = p1[7:0] - 8'd1;
					end
					"G": begin
						wrap_n = 1'b0;
						if (p0 == 16'd0)
							col_n = 8'd0;
						else if (p0 >= 16'(SCREEN_COLS))
							col_n = COL_LAST;
						else
							col_n = p0[7:0] - 8'd1;
					end
					"m": sgr_n = 1'b1;
					"A": begin
						wrap_n = 1'b0;
						row_n = (pn > {8'd0, row_q}) ? 8'd0 : row_q - pn[7:0];
					end
					"B": begin
						wrap_n = 1'b0;
						row_n = (row_plus >= 17'(SCREEN_ROWS)) ? ROW_LAST : row_plus[7:0];
					end
					"C": begin
						wrap_n = 1'b0;
						col_n = (col_plus >= 17'(SCREEN_COLS)) ? COL_LAST : col_plus[7:0];
					end
					"D": begin
						wrap_n = 1'b0;
						col_n = (pn > {8'd0, col_q}) ? 8'd0 : col_q - pn[7:0];
					end
					"E": begin
						col_n = 8'd0;
						wrap_n = 1'b0;
						if (row_plus >= 17'(SCREEN_ROWS)) begin
							s0 = mk_cmd(KIND_SCROLL_UP, 8'd0, 8'd0, ROWS8,
								16'(row_plus - 17'(SCREEN_ROWS - 1)), def_back_q);
							s0v = 1'b1;
							row_n = ROW_LAST;
						end else
							row_n = row_plus[7:0];
					end
					"F": begin
						col_n = 8'd0;
						wrap_n = 1'b0;
						if (pn > {8'd0, row_q}) begin
							s0 = mk_cmd(KIND_SCROLL_DOWN, 8'd0, 8'd0, ROWS8,
								pn - {8'd0, row_q}, def_back_q);
							s0v = 1'b1;
							row_n = 8'd0;
						end else
							row_n = row_q - pn[7:0];
					end
					"S": begin
						s0 = mk_cmd(KIND_SCROLL_UP, 8'd0, 8'd0, ROWS8, pn, def_back_q);
						s0v = 1'b1;
					end
					"T": begin
						s0 = mk_cmd(KIND_SCROLL_DOWN, 8'd0, 8'd0, ROWS8, pn, def_back_q);
						s0v = 1'b1;
					end
					"J", "K": begin
						// modes 0 and 1 leave the cursor cell itself uncleared
						if (p0 == 16'd0) begin
							s0 = mk_cmd(KIND_CLEAR_COLS, row_q, col_q + 8'd1, COLS8,
								16'd0, def_back_q);
							s0v = (col_q != COL_LAST);
							s1 = mk_cmd(KIND_CLEAR_ROWS, row_q + 8'd1, 8'd0, ROWS8,
								16'd0, def_back_q);
							s1v = (byte_q == "J") && (row_q != ROW_LAST);
						end else if (p0 == 16'd1) begin
							s0 = mk_cmd(KIND_CLEAR_COLS, row_q, 8'd0, col_q, 16'd0, def_back_q);
							s0v = (col_q != 8'd0);
							s1 = mk_cmd(KIND_CLEAR_ROWS, 8'd0, 8'd0, row_q, 16'd0, def_back_q);
							s1v = (byte_q == "J") && (row_q != 8'd0);
						end else if (byte_q == "J" && (p0 == 16'd2 || p0 == 16'd3)) begin
							s0 = mk_cmd(KIND_CLEAR_ROWS, 8'd0, 8'd0, ROWS8, 16'd0, def_back_q);
							s0v = 1'b1;
						end else if (byte_q == "K" && p0 == 16'd2) begin
							s0 = mk_cmd(KIND_CLEAR_COLS, row_q, 8'd0, COLS8, 16'd0, def_back_q);
							s0v = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end else begin
			mode_n = MODE_GROUND;
		end
	end

	// SGR walk: one stored parameter per cycle
	assign prm_k = (sgr_k_q < K_W'(MAX_PARAMS)) ? vals_q[sgr_k_q[IDX_W-1:0]] : 16'd0;
	assign sgr_done = (sgr_phase_q == SG_NORMAL) && (sgr_k_q >= K_W'(count_q))
		&& (sgr_k_q != '0);

	always_comb begin
		k_n = sgr_k_q + K_W'(1);
		phase_n = SG_NORMAL;
		tgt_n = sgr_back_q;
		sfont_n = font_q;
		sstyle_n = style_q;
		sfore_n = fore_q;
		sback_n = back_q;
		case (sgr_phase_q)
			SG_NORMAL: begin
				case (prm_k) inside
					16'd0: begin
						sfont_n = 2'd0;
						sstyle_n = 5'd0;
						sfore_n = def_fore_q;
						sback_n = def_back_q;
					end
					16'd1: sfont_n = 2'd1;
					16'd2: sfont_n = 2'd2;
					16'd3: sstyle_n[ST_ITALIC] = 1'b1;
					16'd4: sstyle_n[ST_UNDER] = 1'b1;
					16'd7: sstyle_n[ST_NEG] = 1'b1;
					16'd8: sstyle_n[ST_CONCEAL] = 1'b1;
					16'd9: sstyle_n[ST_CROSS] = 1'b1;
					16'd10, 16'd21, 16'd22, 16'd23: sfont_n = 2'd0;
					16'd24: sstyle_n[ST_UNDER] = 1'b0;
					16'd27: sstyle_n[ST_NEG] = 1'b0;
					16'd28: sstyle_n[ST_CONCEAL] = 1'b0;
					16'd29: sstyle_n[ST_CROSS] = 1'b0;
					16'd38: begin
						phase_n = SG_SUB;
						tgt_n = 1'b0;
					end
					16'd48: begin
						phase_n = SG_SUB;
						tgt_n = 1'b1;
					end
					16'd39: sfore_n = def_fore_q;
					16'd49: sback_n = def_back_q;
					[16'd30:16'd37]: sfore_n = prm_k[7:0] - 8'd30;
					[16'd40:16'd47]: sback_n = prm_k[7:0] - 8'd40;
					[16'd90:16'd97]: sfore_n = prm_k[7:0] - 8'd82;
					[16'd100:16'd107]: sback_n = prm_k[7:0] - 8'd92;
					default: ;
				endcase
			end
			SG_SUB: begin
				if (prm_k == 16'd5)
					phase_n = SG_VAL;
				else begin
					if (sgr_back_q)
						sback_n = def_fore_q;
					else
						sfore_n = def_fore_q;
					// 2 drops the r;g;b triple
					if (prm_k == 16'd2)
						k_n = sgr_k_q + K_W'(4);
				end
			end
			SG_VAL: begin
				if (sgr_back_q)
					sback_n = prm_k[7:0];
				else
					sfore_n = prm_k[7:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_fore_q <= RST_DEF_FORE;
			def_back_q <= RST_DEF_BACK;
			mode_q <= MODE_GROUND;
			for (int i = 0; i < MAX_PARAMS; i++)
				vals_q[i] <= 16'd0;
			count_q <= '0;
			digits_q <= '0;
			row_q <= 8'd0;
			col_q <= 8'd0;
			wrap_q <= 1'b0;
			font_q <= 2'd0;
			style_q <= 5'd0;
			fore_q <= RST_DEF_FORE;
			back_q <= RST_DEF_BACK;
			slot0_v_q <= 1'b0;
			slot1_v_q <= 1'b0;
			tx_kind_q <= TX_NONE;
			tx_idx_q <= 3'd0;
			sgr_pend_q <= 1'b0;
			sgr_k_q <= '0;
			sgr_phase_q <= SG_NORMAL;
			sgr_back_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_DEF_FORE)
					def_fore_q <= cfg_data;
				else
					def_back_q <= cfg_data;
			end
			if (cmd.exec) begin
				if (do_rst) begin
					mode_q <= MODE_GROUND;
					for (int i = 0; i < MAX_PARAMS; i++)
						vals_q[i] <= 16'd0;
					count_q <= '0;
					digits_q <= '0;
					row_q <= 8'd0;
					col_q <= 8'd0;
					wrap_q <= 1'b0;
					font_q <= 2'd0;
					style_q <= 5'd0;
					fore_q <= def_fore_q;
					back_q <= def_back_q;
				end else begin
					mode_q <= mode_n;
					count_q <= count_n;
					digits_q <= digits_n;
					row_q <= row_n;
					col_q <= col_n;
					wrap_q <= wrap_n;
					if (clr_prm)
						for (int i = 0; i < MAX_PARAMS; i++)
							vals_q[i] <= 16'd0;
					else if (wr_en)
						vals_q[wr_idx] <= wr_data;
				end
				slot0_v_q <= s0v;
				slot1_v_q <= s1v;
				tx_kind_q <= tx_n;
				tx_idx_q <= 3'd0;
				sgr_pend_q <= sgr_n;
				sgr_k_q <= '0;
				sgr_phase_q <= SG_NORMAL;
			end else if (cmd.sgr_step) begin
				sgr_k_q <= k_n;
				sgr_phase_q <= phase_n;
				sgr_back_q <= tgt_n;
				font_q <= sfont_n;
				style_q <= sstyle_n;
				fore_q <= sfore_n;
				back_q <= sback_n;
			end
			if (cmd.emit_tx)
				tx_idx_q <= tx_idx_q + 3'd1;
			if (cmd.emit_slot0 || cmd.emit_slot1 || cmd.emit_tx) begin
				out_valid_q <= 1'b1;
				out_last_q <= cmd.last;
			end else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.capture)
			byte_q <= rx_byte;
		if (cmd.exec) begin
			slot0_q <= s0;
			slot1_q <= s1;
		end
		if (cmd.emit_slot0)
			out_q <= slot0_q;
		else if (cmd.emit_slot1)
			out_q <= slot1_q;
		else if (cmd.emit_tx)
			out_q <= mk_cmd(KIND_TRANSMIT, 8'd0, 8'd0, 8'd0,
				{8'd0, tx_byte(tx_kind_q, tx_idx_q)}, 8'd0);
	end

	always_comb begin
		status.slot0_v = slot0_v_q;
		status.slot1_v = slot1_v_q;
		status.tx_pending = (tx_kind_q != TX_NONE);
		status.tx_last = (tx_idx_q == tx_len_m1(tx_kind_q));
		status.sgr_pending = sgr_pend_q;
		status.sgr_done = sgr_done;
		status.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_res = out_q;
	assign out_last = out_last_q;

	`AECE_ASSERT(a_row_range, row_q < ROWS8, "cursor row off screen")
	`AECE_ASSERT(a_col_range, col_q < COLS8, "cursor column off screen")
	`AECE_ASSERT(a_count_range, count_q <= CNT_W'(MAX_PARAMS), "parameter count overflow")

endmodule

`default_nettype wire

// File: hdl/ansi_escape_command_engine.sv
// ---------------------------------------------------------------------------
// ansi_escape_command_engine
// VT100/ANSI escape parser producing terminal drawing commands.
// ---------------------------------------------------------------------------
// One received byte is taken per in_valid/in_ready beat and turned into zero
// to seven command beats on the out channel; the final beat of each byte has
// last set. A byte is handled one at a time: in_ready stays low while the
// sequencer takes the byte through its execute step, a route step, the SGR
// walk if any, and one emit step per command beat, which waits while
// out_ready holds the output register full. The SGR walk reads one parameter
// per cycle (at least one; the three values skipped after 38;2 or 48;2 are
// not read) and then ends the walk in a step of its own. A single output
// register drains one command per cycle while out_ready is high; it lets the
// last command of a byte wait on out_ready while the next byte is accepted.
// Default colours are written on the cfg port (index 0
// foreground, 1 background) while the engine is idle; they take effect at
// ESC c and SGR 0/39/49, and at once in scroll and clear commands; reset
// restores the built-in defaults. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ansi_escape_command_engine #(
	parameter int SCREEN_ROWS = aece_pkg::DEF_SCREEN_ROWS,
	parameter int SCREEN_COLS = aece_pkg::DEF_SCREEN_COLS,
	parameter int MAX_PARAMS  = aece_pkg::DEF_MAX_PARAMS,
	parameter int PARAM_CHARS = aece_pkg::DEF_PARAM_CHARS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// received bytes
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [7:0]                      rx_byte,
	// command beats
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [2:0]                      kind,
	output logic [7:0]                      pos_row,
	output logic [7:0]                      pos_col,
	output logic [7:0]                      span_end,
	output logic [15:0]                     value,
	output logic [1:0]                      font_kind,
	output logic                            italic_on,
	output logic                            underline_on,
	output logic                            strike_on,
	output logic [7:0]                      fore_color,
	output logic [7:0]                      back_color,
	output logic                            last,
	// register writes
	input  wire                             cfg_we,
	input  wire  [aece_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [7:0]                      cfg_data
);
	import aece_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	result_t    res;

	aece_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	aece_dp #(
		.SCREEN_ROWS (SCREEN_ROWS),
		.SCREEN_COLS (SCREEN_COLS),
		.MAX_PARAMS  (MAX_PARAMS),
		.PARAM_CHARS (PARAM_CHARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res),
		.out_last  (last)
	);

	// fan the command word out to its ports
	assign kind         = res.kind;
	assign pos_row      = res.pos_row;
	assign pos_col      = res.pos_col;
	assign span_end     = res.span_end;
	assign value        = res.value;
	assign font_kind    = res.font_kind;
	assign italic_on    = res.italic_on;
	assign underline_on = res.underline_on;
	assign strike_on    = res.strike_on;
	assign fore_color   = res.fore_color;
	assign back_color   = res.back_color;

endmodule

`default_nettype wire

// File: test/tb_ansi_escape_command_engine.sv
// ---------------------------------------------------------------------------
// tb_ansi_escape_command_engine
// Byte-stream check of the escape command engine against a behavioural model.
// ---------------------------------------------------------------------------
// Received bytes go in on the in channel. Every accepted beat is run through a
// scoreboard that tracks parse mode, parameters, cursor and SGR state, and
// queues the command beats that the byte should produce. Command beats seen on
// the out channel are compared field by field, oldest first. The stimulus is a
// directed run of escape sequences followed by random sequences, mostly well
// formed, with random idling on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_ansi_escape_command_engine;

	import aece_pkg::*;

	localparam int ROWS   = DEF_SCREEN_ROWS;
	localparam int COLS   = DEF_SCREEN_COLS;
	localparam int NPARAM = DEF_MAX_PARAMS;
	localparam int NCHARS = DEF_PARAM_CHARS;
	localparam int SETTLE = 40;   // settle wait, in clock cycles, for a byte that emits nothing

	typedef enum logic [1:0] {PM_GROUND, PM_ESC, PM_CSI, PM_HASH} parse_mode_t;

	// style bits
	localparam int ST_ITALIC  = 0;
	localparam int ST_UNDER   = 1;
	localparam int ST_NEG     = 2;
	localparam int ST_CONCEAL = 3;
	localparam int ST_CROSS   = 4;

	typedef struct {
		result_t    r;
		logic       last;
	} cmd_beat_t;

	// -----------------------------------------------------------------------
	// scoreboard: terminal state model and queue of expected command beats
	// -----------------------------------------------------------------------
	class cmd_scoreboard;
		logic [7:0]  def_fore = RST_DEF_FORE;
		logic [7:0]  def_back = RST_DEF_BACK;
		parse_mode_t mode;
		logic [15:0] params [NPARAM];
		int          nparams, ndigits;
		int          row, col;
		bit          wrap;
		logic [1:0]  font;
		logic [4:0]  style;
		logic [1:0]  blink;
		logic [7:0]  fore_st, back_st;
		result_t     byte_cmds[$];
		cmd_beat_t   expected_q[$];

		function new();
			clear_state();
		endfunction

		function void clear_state();
			mode = PM_GROUND;
			foreach (params[i]) params[i] = '0;
			nparams = 0; ndigits = 0;
			row = 0; col = 0; wrap = 0;
			font = '0; style = '0; blink = '0;
			fore_st = def_fore; back_st = def_back;
		endfunction

		function int prm(int idx);
			return (idx < NPARAM) ? int'(params[idx]) : 0;
		endfunction

		function int prm_or_one();
			return (prm(0) != 0) ? prm(0) : 1;
		endfunction

		function void add_cmd(logic [2:0] k, int r0, int c0, int span, int val);
			result_t r;
			r = '0;
			r.kind = k; r.pos_row = r0[7:0]; r.pos_col = c0[7:0];
			r.span_end = span[7:0]; r.value = val[15:0];
			if (k inside {KIND_SCROLL_UP, KIND_SCROLL_DOWN, KIND_CLEAR_ROWS,
					KIND_CLEAR_COLS})
				r.back_color = def_back;
			byte_cmds.push_back(r);
		endfunction

		function void move_to(int r0, int c0);
			if (c0 < 0) c0 = 0;
			if (r0 < 0) r0 = 0;
			if (c0 >= COLS) c0 = COLS - 1;
			if (r0 >= ROWS) r0 = ROWS - 1;
			row = r0; col = c0; wrap = 0;
		endfunction

		function void line_down(int n);
			if (row >= ROWS - n) begin
				add_cmd(KIND_SCROLL_UP, 0, 0, ROWS, n - (ROWS - 1 - row));
				row = ROWS - 1;
			end else
				row += n;
		endfunction

		function void line_up(int n);
			if (row < n) begin
				add_cmd(KIND_SCROLL_DOWN, 0, 0, ROWS, n - row);
				row = 0;
			end else
				row -= n;
		endfunction

		function void draw_char(logic [7:0] ch);
			result_t r;
			bit neg;
			if (wrap) begin
				col = 0; wrap = 0;
				line_down(1);
			end
			if (!style[ST_CONCEAL]) begin
				neg = style[ST_NEG];
				r = '0;
				r.kind = KIND_DRAW; r.pos_row = row[7:0]; r.pos_col = col[7:0];
				r.value = {8'h00, ch};
				r.font_kind = font;
				r.italic_on = style[ST_ITALIC];
				r.underline_on = style[ST_UNDER];
				r.strike_on = style[ST_CROSS];
				r.fore_color = neg ? back_st : fore_st;
				r.back_color = neg ? fore_st : back_st;
				byte_cmds.push_back(r);
			end
			if (col == COLS - 1) wrap = 1;
			else col++;
		endfunction

		// 38/48 sub-parameters: 5;n indexed, 2;r;g;b skipped
		function logic [7:0] ext_color(inout int i);
			int sub;
			sub = prm(i); i++;
			if (sub == 5) begin
				sub = prm(i); i++;
				return sub[7:0];
			end
			if (sub == 2) i += 3;
			return def_fore;
		endfunction

		function void sgr_one(inout int i);
			int c;
			c = prm(i); i++;
			case (c)
				0: begin
					font = '0; style = '0; blink = '0;
					fore_st = def_fore; back_st = def_back;
				end
				1: font = 2'd1;
				2: font = 2'd2;
				3: style[ST_ITALIC] = 1;
				4: style[ST_UNDER] = 1;
				5: blink = 2'd1;
				6: blink = 2'd2;
				7: style[ST_NEG] = 1;
				8: style[ST_CONCEAL] = 1;
				9: style[ST_CROSS] = 1;
				10, 21, 22, 23: font = '0;
				24: style[ST_UNDER] = 0;
				25: blink = '0;
				27: style[ST_NEG] = 0;
				28: style[ST_CONCEAL] = 0;
				29: style[ST_CROSS] = 0;
				38: fore_st = ext_color(i);
				39: fore_st = def_fore;
				48: back_st = ext_color(i);
				49: back_st = def_back;
				default: begin
					if (c >= 30 && c < 38) fore_st = 8'(c - 30);
					else if (c >= 40 && c < 48) back_st = 8'(c - 40);
					else if (c >= 90 && c < 98) fore_st = 8'(c - 90 + 8);
					else if (c >= 100 && c < 108) back_st = 8'(c - 100 + 8);
				end
			endcase
		endfunction

		function void csi_final(logic [7:0] b);
			logic [7:0] da [7];
			logic [7:0] dsr [4];
			int k;
			da = '{CH_ESC, "[", "?", "1", ";", "0", "c"};
			dsr = '{CH_ESC, "[", "0", "n"};
			case (b)
				"c": for (k = 0; k < 7; k++) add_cmd(KIND_TRANSMIT, 0, 0, 0, da[k]);
				"n": if (prm(0) == 5)
					for (k = 0; k < 4; k++) add_cmd(KIND_TRANSMIT, 0, 0, 0, dsr[k]);
				"f", "H": move_to(prm(0) - 1, prm(1) - 1);
				"m": begin
					k = 0;
					if (nparams != 0) begin
						while (k < nparams) sgr_one(k);
					end else
						sgr_one(k);
				end
				"A": move_to(row - prm_or_one(), col);
				"B": move_to(row + prm_or_one(), col);
				"C": move_to(row, col + prm_or_one());
				"D": move_to(row, col - prm_or_one());
				"E", "F": begin
					k = prm_or_one();
					col = 0; wrap = 0;
					if (b == "E") line_down(k);
					else line_up(k);
				end
				"G": move_to(row, prm(0) - 1);
				"S": add_cmd(KIND_SCROLL_UP, 0, 0, ROWS, prm_or_one());
				"T": add_cmd(KIND_SCROLL_DOWN, 0, 0, ROWS, prm_or_one());
				"J", "K": begin
					k = prm(0);
					// modes 0 and 1 leave the cursor cell itself uncleared
					if (k == 0) begin
						if (col != COLS - 1) add_cmd(KIND_CLEAR_COLS, row, col + 1, COLS, 0);
						if (b == "J" && row != ROWS - 1)
							add_cmd(KIND_CLEAR_ROWS, row + 1, 0, ROWS, 0);
					end else if (k == 1) begin
						if (col != 0) add_cmd(KIND_CLEAR_COLS, row, 0, col, 0);
						if (b == "J" && row != 0) add_cmd(KIND_CLEAR_ROWS, 0, 0, row, 0);
					end else if (b == "J" && (k == 2 || k == 3))
						add_cmd(KIND_CLEAR_ROWS, 0, 0, ROWS, 0);
					else if (b == "K" && k == 2)
						add_cmd(KIND_CLEAR_COLS, row, 0, COLS, 0);
				end
				default: ;
			endcase
			mode = PM_GROUND;
		endfunction

		function void csi_byte(logic [7:0] b);
			if (b >= "0" && b <= "9") begin
				if (ndigits == 0) begin
					if (nparams >= NPARAM) return;
					nparams++;
				end
				if (ndigits >= NCHARS - 1) return;
				ndigits++;
				params[nparams-1] = params[nparams-1] * 16'd10 + 16'(b - "0");
			end else if (b == ";") begin
				if (ndigits == 0) begin
					if (nparams < NPARAM) nparams++;
				end else
					ndigits = 0;
			end else
				csi_final(b);
		endfunction

		// one accepted input beat
		function void note_byte(logic [7:0] b);
			cmd_beat_t e;
			byte_cmds.delete();
			if (b == CH_CR) begin
				col = 0; wrap = 0;
			end else if (b == CH_LF)
				line_down(1);
			else if (b == CH_ESC)
				mode = PM_ESC;
			else if (mode == PM_GROUND)
				draw_char(b);
			else if (mode == PM_ESC) begin
				if (b == "[") begin
					mode = PM_CSI;
					foreach (params[i]) params[i] = '0;
					nparams = 0; ndigits = 0;
				end else if (b == "#")
					mode = PM_HASH;
				else if (b == "c") begin
					add_cmd(KIND_RESET, 0, 0, 0, 0);
					clear_state();
				end else
					mode = PM_GROUND;
			end else if (mode == PM_CSI)
				csi_byte(b);
			else
				mode = PM_GROUND;
			foreach (byte_cmds[i]) begin
				e.r = byte_cmds[i];
				e.last = (i == byte_cmds.size() - 1);
				expected_q.push_back(e);
			end
		endfunction

		// one accepted output beat; empty string when it matches
		function string check(cmd_beat_t got);
			cmd_beat_t e;
			string m;
			if (expected_q.size() == 0)
				return $sformatf("unexpected beat kind %0d value %h", got.r.kind, got.r.value);
			e = expected_q.pop_front();
			m = "";
			if (got.r.kind !== e.r.kind)
				m = {m, $sformatf(" kind %0d/%0d", got.r.kind, e.r.kind)};
			if (got.r.pos_row !== e.r.pos_row)
				m = {m, $sformatf(" pos_row %0d/%0d", got.r.pos_row, e.r.pos_row)};
			if (got.r.pos_col !== e.r.pos_col)
				m = {m, $sformatf(" pos_col %0d/%0d", got.r.pos_col, e.r.pos_col)};
			if (got.r.span_end !== e.r.span_end)
				m = {m, $sformatf(" span_end %0d/%0d", got.r.span_end, e.r.span_end)};
			if (got.r.value !== e.r.value)
				m = {m, $sformatf(" value %h/%h", got.r.value, e.r.value)};
			if (got.r.font_kind !== e.r.font_kind)
				m = {m, $sformatf(" font_kind %0d/%0d", got.r.font_kind, e.r.font_kind)};
			if (got.r.italic_on !== e.r.italic_on)
				m = {m, $sformatf(" italic_on %b/%b", got.r.italic_on, e.r.italic_on)};
			if (got.r.underline_on !== e.r.underline_on)
				m = {m, $sformatf(" underline_on %b/%b", got.r.underline_on,
					e.r.underline_on)};
			if (got.r.strike_on !== e.r.strike_on)
				m = {m, $sformatf(" strike_on %b/%b", got.r.strike_on, e.r.strike_on)};
			if (got.r.fore_color !== e.r.fore_color)
				m = {m, $sformatf(" fore_color %0d/%0d", got.r.fore_color, e.r.fore_color)};
			if (got.r.back_color !== e.r.back_color)
				m = {m, $sformatf(" back_color %0d/%0d", got.r.back_color, e.r.back_color)};
			if (got.last !== e.last)
				m = {m, $sformatf(" last %b/%b", got.last, e.last)};
			if (m != "") m = {"mismatch (got/exp):", m};
			return m;
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// DUT and signals
	// -----------------------------------------------------------------------
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic [7:0] rx_byte = '0;
	logic out_valid, out_ready = 0;
	logic [2:0] kind;
	logic [7:0] pos_row, pos_col, span_end, fore_color, back_color;
	logic [15:0] value;
	logic [1:0] font_kind;
	logic italic_on, underline_on, strike_on, last;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	ansi_escape_command_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .pos_row(pos_row), .pos_col(pos_col), .span_end(span_end),
		.value(value), .font_kind(font_kind), .italic_on(italic_on),
		.underline_on(underline_on), .strike_on(strike_on),
		.fore_color(fore_color), .back_color(back_color), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cmd_scoreboard sb = new();
	int  err_count = 0;
	bit  idle_en = 1;    // random idling on both channels
	int  sent = 0;
	int  total_sent = 0;

	always #5 clk = ~clk;

	task automatic report(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// sink side: out_ready is dropped at random, about 7 percent of the time, when idling is on
	always @(posedge clk)
		out_ready <= idle_en ? ($urandom_range(0, 99) >= 7) : 1'b1;

	// command beat monitor
	always @(posedge clk) begin
		cmd_beat_t got;
		string msg;
		if (arst_n && out_valid && out_ready) begin
			got.r.kind = kind; got.r.pos_row = pos_row; got.r.pos_col = pos_col;
			got.r.span_end = span_end; got.r.value = value; got.r.font_kind = font_kind;
			got.r.italic_on = italic_on; got.r.underline_on = underline_on;
			got.r.strike_on = strike_on; got.r.fore_color = fore_color;
			got.r.back_color = back_color; got.last = last;
			msg = sb.check(got);
			if (msg != "") report(msg);
		end
	end

	// one byte beat; valid held until accepted
	task automatic send_byte(logic [7:0] b);
		if (idle_en && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
		sent++;
		total_sent++;
	endtask

	task automatic send_str(string s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	task automatic send_num(int n);
		send_str($sformatf("%0d", n));
	endtask

	// wait for every expected beat, then let a silent byte settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// only called with the engine idle
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEF_FORE) sb.def_fore = val;
		else sb.def_back = val;
	endtask

	// one random group: mostly well-formed CSI with random content
	task automatic random_group();
		int r, n, i, j;
		int sgr_codes [30];
		string finals;
		sgr_codes = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 21, 22, 23, 24, 25, 27, 28, 29,
			31, 39, 44, 49, 95, 103, 38, 48, 5, 2, 200};
		finals = "ABCDEFGHJKSTfmncyHm";
		r = $urandom_range(0, 99);
		if (r < 35) begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				j = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(32, 126);
				if (j == CH_ESC) j = "x";
				send_byte(8'(j));
			end
		end else if (r < 80) begin
			send_byte(CH_ESC);
			send_byte("[");
			j = $urandom_range(0, finals.len() - 1);
			n = ($urandom_range(0, 9) == 0) ? 10 : $urandom_range(0, 4);
			for (i = 0; i < n; i++) begin
				if (i != 0) send_byte(";");
				if ($urandom_range(0, 5) != 0) begin
					if (finals[j] == "m") send_num(sgr_codes[$urandom_range(0, 29)]);
					else if ($urandom_range(0, 7) == 0) send_num($urandom_range(0, 999999));
					else send_num($urandom_range(0, 90));
				end
			end
			send_byte(finals[j]);
		end else if (r < 90) begin
			case ($urandom_range(0, 4))
				0: send_byte(CH_CR);
				1: send_byte(CH_LF);
				2: send_str({CH_ESC, "c"});
				3: begin send_str({CH_ESC, "#"}); send_byte(8'($urandom_range(0, 255))); end
				default: begin send_byte(CH_ESC); send_byte(8'($urandom_range(0, 255))); end
			endcase
		end else
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic random_run(int count);
		while (count > 0) begin
			// a long stretch with no idling on either side
			idle_en = !(total_sent >= 250 && total_sent < 320);
			sent = 0;
			random_group();
			count -= sent;
		end
		sent = 0;
		idle_en = 1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: draws, controls, every final and the special cases
		send_str("A~");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_str({CH_CR, CH_LF});
		send_str({CH_ESC, "[c"});
		send_str({CH_ESC, "[5n", CH_ESC, "[6n"});
		send_str({CH_ESC, "[24;80H", "xy"});               // deferred wrap and scroll
		send_str({CH_ESC, "[99;99f", CH_ESC, "[H", CH_ESC, "[2B", CH_ESC, "[5C"});
		send_str({CH_ESC, "[1;3;4;9;31;44m", "b"});
		send_str({CH_ESC, "[7m", "n", CH_ESC, "[27m", "p"});  // negative then cleared
		send_str({CH_ESC, "[38;5;200;48;2;1;2;3;97m", "c"});
		send_str({CH_ESC, "[38;9m", CH_ESC, "[8m", "h", CH_ESC, "[m", "v"});
		send_str({CH_ESC, "[J", CH_ESC, "[1J", CH_ESC, "[2J", CH_ESC, "[3K"});
		send_str({CH_ESC, "[K", CH_ESC, "[1K", CH_ESC, "[2K"});
		send_str({CH_ESC, "[3S", CH_ESC, "[T", CH_ESC, "[30F", CH_ESC, "[40E"});
		send_str({CH_ESC, "[123456G", CH_ESC, "[1;2;3;4;5;6;7;8;9;10;11H", CH_ESC, "[y"});
		send_str({CH_ESC, "[1", CH_LF, "A", CH_ESC, "#8", "q", CH_ESC, "Z", CH_ESC, "c"});
		drain();

		// extreme default colours
		write_cfg(CFG_DEF_FORE, 8'd0);
		write_cfg(CFG_DEF_BACK, 8'd255);
		send_str({CH_ESC, "c", "d", CH_ESC, "[7mi", CH_ESC, "[J"});
		random_run(40);
		drain();

		write_cfg(CFG_DEF_FORE, 8'd255);
		write_cfg(CFG_DEF_BACK, 8'd0);
		send_str({CH_ESC, "c"});
		random_run(30);
		// sender holds off until every expected beat has arrived
		drain();
		random_run(30);
		drain();

		write_cfg(CFG_DEF_FORE, 8'($urandom_range(0, 255)));
		write_cfg(CFG_DEF_BACK, 8'($urandom_range(0, 255)));
		send_str({CH_ESC, "c"});
		random_run(40);
		drain();

		if (sb.expected_q.size() != 0)
			report($sformatf("%0d expected beats never arrived", sb.expected_q.size()));
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
